@@ rtl/prlc_pkg.sv @@
// ----------------------------------------------------------------------------
// prlc_pkg
// Shared types and codes of the paired read linker classifier.
// ----------------------------------------------------------------------------
package prlc_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 64;
    localparam int LINKER_W = 64;
    localparam int LEN_CFG_W = 6;
    localparam int RESCUE_W = 3;
    localparam int BOUND_W = 9;
    localparam int CUT_W = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_LINKER_A = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINKER_B = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LINKER_A_LEN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LINKER_B_LEN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RESCUE_MODE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEN = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN = 3'd6;

    localparam logic [RESCUE_W-1:0] RESCUE_FIRST = 3'd1;
    localparam logic [RESCUE_W-1:0] RESCUE_SECOND = 3'd2;
    localparam logic [RESCUE_W-1:0] RESCUE_ANY = 3'd3;
    localparam logic [RESCUE_W-1:0] RESCUE_BOTH = 3'd4;

    localparam logic [LEN_CFG_W-1:0] LINKER_LEN_RESET = 6'd16;
    localparam logic [BOUND_W-1:0] MAX_LEN_RESET = 9'd256;

    typedef enum logic [1:0] {
        LT_NONE = 2'd0,
        LT_A    = 2'd1,
        LT_B    = 2'd2
    } t_ltype;

    typedef enum logic [1:0] {
        CLS_AMBIGUOUS = 2'd0,
        CLS_USABLE    = 2'd1,
        CLS_CHIMERIC  = 2'd2,
        CLS_HAS_N     = 2'd3
    } t_class;

    typedef struct packed {
        logic       mate;
        logic [2:0] base;
        logic       read_end;
    } t_in_item;

    typedef struct packed {
        logic [1:0]       pair_class;
        logic [CUT_W-1:0] cut_first;
        logic [CUT_W-1:0] cut_second;
    } t_out_item;

    typedef struct packed {
        logic   n_seen;
        t_ltype type_first;
        t_ltype type_second;
    } t_pair_ctl;

endpackage

@@ rtl/paired_read_linker_classifier.sv @@
// ----------------------------------------------------------------------------
// paired_read_linker_classifier
// Streams the bases of a read pair through a row of window cells, finds the
// first linker A and B start in each read and classifies the pair.
//
// Channel   Direction  Handshake                 Item
// in        input      i_in_valid / o_in_ready   one base: mate, base, read_end
// out       output     o_out_valid / i_out_ready one pair: class, two cuts
// cfg       input      i_cfg_we                  register index and data
//
// One base is taken every cycle unless the input stalls. After the base that
// closes mate 2, its pair passes in turn through the window cells, the tracker
// and the output register. The input stalls only while a finished pair record
// and the output register are both held by a waiting consumer. Reset is
// synchronous and clears all control state at once; there is no clearing pass.
// ----------------------------------------------------------------------------
module paired_read_linker_classifier #(
    parameter int MAX_READ = 256,
    parameter int MAX_LINKER = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  prlc_pkg::t_in_item                   i_in_data,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output prlc_pkg::t_out_item                  o_out_data,
    input  logic                                 i_cfg_we,
    input  logic [prlc_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [prlc_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int NC = MAX_LINKER;
    localparam int CW = $clog2(MAX_READ + 1);
    localparam int LKW = $clog2(MAX_LINKER + 1);

    logic [prlc_pkg::LINKER_W-1:0]  r_linker_a;
    logic [prlc_pkg::LINKER_W-1:0]  r_linker_b;
    logic [prlc_pkg::LEN_CFG_W-1:0] r_len_a_cfg;
    logic [prlc_pkg::LEN_CFG_W-1:0] r_len_b_cfg;
    logic [prlc_pkg::RESCUE_W-1:0]  r_rescue;
    logic [prlc_pkg::BOUND_W-1:0]   r_min_len;
    logic [prlc_pkg::BOUND_W-1:0]   r_max_len;

    logic [LKW-1:0]  r_len_a;
    logic [LKW-1:0]  r_len_b;
    logic [2*NC-1:0] r_pat_a;
    logic [2*NC-1:0] r_pat_b;
    logic [NC-1:0]   r_use_a;
    logic [NC-1:0]   r_use_b;

    logic [LKW-1:0]  n_len_a;
    logic [LKW-1:0]  n_len_b;
    logic [prlc_pkg::LINKER_W-1:0] w_sh_a;
    logic [prlc_pkg::LINKER_W-1:0] w_sh_b;
    logic [NC-1:0]   n_use_a;
    logic [NC-1:0]   n_use_b;

    logic [CW-1:0]   r_cnt;
    logic            r_s1_valid;
    logic            r_s1_room;
    logic [CW-1:0]   r_s1_count;
    logic            r_s1_last;
    logic            r_s1_mate;
    logic            r_s1_nbase;

    logic            w_en;
    logic            w_accept;
    logic            w_room;
    logic [CW-1:0]   n_cnt;
    logic [1:0]      w_code;
    logic [1:0]      w_chain [NC+1];
    logic [NC-1:0]   w_hit_a;
    logic [NC-1:0]   w_hit_b;

    logic                 w_pr_valid;
    prlc_pkg::t_pair_ctl  w_pr_ctl;
    logic [CW-1:0]        w_pos_first;
    logic [CW-1:0]        w_len_first;
    logic [CW-1:0]        w_pos_second;
    logic [CW-1:0]        w_len_second;
    logic                 w_take;

    function automatic logic [LKW-1:0] eff_len(input logic [prlc_pkg::LEN_CFG_W-1:0] len);
        logic [LKW-1:0] res;
        if (len == '0) begin
            res = LKW'(1);
        end else if (int'(len) > MAX_LINKER) begin
            res = LKW'(MAX_LINKER);
        end else begin
            res = LKW'(len);
        end
        return res;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_linker_a <= '0;
            r_linker_b <= '0;
            r_len_a_cfg <= prlc_pkg::LINKER_LEN_RESET;
            r_len_b_cfg <= prlc_pkg::LINKER_LEN_RESET;
            r_rescue <= '0;
            r_min_len <= '0;
            r_max_len <= prlc_pkg::MAX_LEN_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                prlc_pkg::CFG_LINKER_A: begin
                    r_linker_a <= i_cfg_data;
                end
                prlc_pkg::CFG_LINKER_B: begin
                    r_linker_b <= i_cfg_data;
                end
                prlc_pkg::CFG_LINKER_A_LEN: begin
                    r_len_a_cfg <= i_cfg_data[prlc_pkg::LEN_CFG_W-1:0];
                end
                prlc_pkg::CFG_LINKER_B_LEN: begin
                    r_len_b_cfg <= i_cfg_data[prlc_pkg::LEN_CFG_W-1:0];
                end
                prlc_pkg::CFG_RESCUE_MODE: begin
                    r_rescue <= i_cfg_data[prlc_pkg::RESCUE_W-1:0];
                end
                prlc_pkg::CFG_MIN_LEN: begin
                    r_min_len <= i_cfg_data[prlc_pkg::BOUND_W-1:0];
                end
                prlc_pkg::CFG_MAX_LEN: begin
                    r_max_len <= i_cfg_data[prlc_pkg::BOUND_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Linkers are aligned so that the last linker base sits on the newest cell.
    always_comb begin
        n_len_a = eff_len(r_len_a_cfg);
        n_len_b = eff_len(r_len_b_cfg);
        w_sh_a = r_linker_a << (2 * (NC - int'(n_len_a)));
        w_sh_b = r_linker_b << (2 * (NC - int'(n_len_b)));
        for (int k = 0; k < NC; k++) begin
            n_use_a[k] = (k >= NC - int'(n_len_a));
            n_use_b[k] = (k >= NC - int'(n_len_b));
        end
    end

    always_ff @(posedge i_clk) begin
        r_len_a <= n_len_a;
        r_len_b <= n_len_b;
        r_pat_a <= w_sh_a[2*NC-1:0];
        r_pat_b <= w_sh_b[2*NC-1:0];
        r_use_a <= n_use_a;
        r_use_b <= n_use_b;
    end

    always_comb begin
        w_en = !w_pr_valid || w_take;
        w_accept = i_in_valid && w_en;
        w_room = (r_cnt < CW'(MAX_READ));
        n_cnt = w_room ? (r_cnt + CW'(1)) : r_cnt;
        w_code = i_in_data.base[2] ? 2'd0 : i_in_data.base[1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_s1_valid <= 1'b0;
        end else if (w_en) begin
            r_s1_valid <= w_accept;
            if (w_accept) begin
                r_cnt <= i_in_data.read_end ? '0 : n_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_room <= w_room;
            r_s1_count <= n_cnt;
            r_s1_last <= i_in_data.read_end;
            r_s1_mate <= i_in_data.mate;
            r_s1_nbase <= i_in_data.base[2];
        end
    end

    assign w_chain[NC] = w_code;

    for (genvar k = 0; k < NC; k++) begin : g_cell
        prlc_cell u_cell (
            .i_clk   (i_clk),
            .i_shift (w_accept),
            .i_base  (w_chain[k+1]),
            .i_pat_a (r_pat_a[2*k+1:2*k]),
            .i_use_a (r_use_a[k]),
            .i_pat_b (r_pat_b[2*k+1:2*k]),
            .i_use_b (r_use_b[k]),
            .o_base  (w_chain[k]),
            .o_hit_a (w_hit_a[k]),
            .o_hit_b (w_hit_b[k])
        );
    end

    prlc_track #(
        .CW  (CW),
        .LKW (LKW)
    ) u_track (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (r_s1_valid && w_en),
        .i_room       (r_s1_room),
        .i_count      (r_s1_count),
        .i_last       (r_s1_last),
        .i_mate       (r_s1_mate),
        .i_nbase      (r_s1_nbase),
        .i_hit_a      (&w_hit_a),
        .i_hit_b      (&w_hit_b),
        .i_len_a      (r_len_a),
        .i_len_b      (r_len_b),
        .i_take       (w_take),
        .o_pr_valid   (w_pr_valid),
        .o_pr_ctl     (w_pr_ctl),
        .o_pos_first  (w_pos_first),
        .o_len_first  (w_len_first),
        .o_pos_second (w_pos_second),
        .o_len_second (w_len_second)
    );

    prlc_class #(
        .CW (CW)
    ) u_class (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pr_valid   (w_pr_valid),
        .i_pr_ctl     (w_pr_ctl),
        .i_pos_first  (w_pos_first),
        .i_len_first  (w_len_first),
        .i_pos_second (w_pos_second),
        .i_len_second (w_len_second),
        .i_rescue     (r_rescue),
        .i_min_len    (r_min_len),
        .i_max_len    (r_max_len),
        .i_out_ready  (i_out_ready),
        .o_take       (w_take),
        .o_out_valid  (o_out_valid),
        .o_out_data   (o_out_data)
    );

    assign o_in_ready = w_en;

`ifndef NO_ASSERTIONS
    a_stall_only_when_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (w_pr_valid && o_out_valid))
        else $error("input stalled without a held pair record and result");

    a_pair_end_records : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && w_en && r_s1_last && r_s1_mate) |=> w_pr_valid)
        else $error("closing base of mate 2 did not produce a pair record");

    a_take_fills_output : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |=> o_out_valid)
        else $error("pair record taken but no result item presented");

    a_count_bounded : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MAX_READ))
        else $error("base count passed its saturation limit");
`endif

endmodule

@@ rtl/prlc_cell.sv @@
// ----------------------------------------------------------------------------
// prlc_cell
// One base of the shift window, compared against the aligned linker bases.
// ----------------------------------------------------------------------------
module prlc_cell (
    input  logic       i_clk,
    input  logic       i_shift,
    input  logic [1:0] i_base,
    input  logic [1:0] i_pat_a,
    input  logic       i_use_a,
    input  logic [1:0] i_pat_b,
    input  logic       i_use_b,
    output logic [1:0] o_base,
    output logic       o_hit_a,
    output logic       o_hit_b
);

    logic [1:0] r_base;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_base <= i_base;
        end
    end

    assign o_base = r_base;
    assign o_hit_a = !i_use_a || (r_base == i_pat_a);
    assign o_hit_b = !i_use_b || (r_base == i_pat_b);

endmodule

@@ rtl/prlc_track.sv @@
// ----------------------------------------------------------------------------
// prlc_track
// Per-read linker tracking and the pair record handed to the classifier.
// ----------------------------------------------------------------------------
module prlc_track #(
    parameter int CW = 9,
    parameter int LKW = 6
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic                 i_room,
    input  logic [CW-1:0]        i_count,
    input  logic                 i_last,
    input  logic                 i_mate,
    input  logic                 i_nbase,
    input  logic                 i_hit_a,
    input  logic                 i_hit_b,
    input  logic [LKW-1:0]       i_len_a,
    input  logic [LKW-1:0]       i_len_b,
    input  logic                 i_take,
    output logic                 o_pr_valid,
    output prlc_pkg::t_pair_ctl  o_pr_ctl,
    output logic [CW-1:0]        o_pos_first,
    output logic [CW-1:0]        o_len_first,
    output logic [CW-1:0]        o_pos_second,
    output logic [CW-1:0]        o_len_second
);

    localparam int CMPW = (CW > LKW) ? CW : LKW;

    logic             r_found_a;
    logic             r_found_b;
    logic [CW-1:0]    r_pos_a;
    logic [CW-1:0]    r_pos_b;
    logic             r_n_seen;
    prlc_pkg::t_ltype r_first_type;
    logic [CW-1:0]    r_first_pos;
    logic [CW-1:0]    r_first_len;
    logic             r_pr_valid;
    prlc_pkg::t_pair_ctl r_pr_ctl;
    logic [CW-1:0]    r_pos_first;
    logic [CW-1:0]    r_len_first;
    logic [CW-1:0]    r_pos_second;
    logic [CW-1:0]    r_len_second;

    logic             n_found_a;
    logic             n_found_b;
    logic [CW-1:0]    n_pos_a;
    logic [CW-1:0]    n_pos_b;
    prlc_pkg::t_ltype w_type;
    logic [CW-1:0]    w_pos;

    always_comb begin
        n_found_a = r_found_a || (i_hit_a && i_room && (CMPW'(i_count) >= CMPW'(i_len_a)));
        n_found_b = r_found_b || (i_hit_b && i_room && (CMPW'(i_count) >= CMPW'(i_len_b)));
        n_pos_a = r_found_a ? r_pos_a : (i_count - CW'(i_len_a));
        n_pos_b = r_found_b ? r_pos_b : (i_count - CW'(i_len_b));
        if (n_found_a && (!n_found_b || (n_pos_a <= n_pos_b))) begin
            w_type = prlc_pkg::LT_A;
            w_pos = n_pos_a;
        end else if (n_found_b) begin
            w_type = prlc_pkg::LT_B;
            w_pos = n_pos_b;
        end else begin
            w_type = prlc_pkg::LT_NONE;
            w_pos = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found_a <= 1'b0;
            r_found_b <= 1'b0;
            r_pos_a <= '0;
            r_pos_b <= '0;
            r_n_seen <= 1'b0;
            r_first_type <= prlc_pkg::LT_NONE;
            r_first_pos <= '0;
            r_first_len <= '0;
            r_pr_valid <= 1'b0;
        end else begin
            if (i_take) begin
                r_pr_valid <= 1'b0;
            end
            if (i_step) begin
                if (i_last) begin
                    r_found_a <= 1'b0;
                    r_found_b <= 1'b0;
                    r_pos_a <= '0;
                    r_pos_b <= '0;
                    if (!i_mate) begin
                        r_first_type <= w_type;
                        r_first_pos <= w_pos;
                        r_first_len <= i_count;
                        r_n_seen <= r_n_seen || i_nbase;
                    end else begin
                        r_first_type <= prlc_pkg::LT_NONE;
                        r_first_pos <= '0;
                        r_first_len <= '0;
                        r_n_seen <= 1'b0;
                        r_pr_valid <= 1'b1;
                    end
                end else begin
                    r_found_a <= n_found_a;
                    r_found_b <= n_found_b;
                    r_pos_a <= n_found_a ? n_pos_a : '0;
                    r_pos_b <= n_found_b ? n_pos_b : '0;
                    r_n_seen <= r_n_seen || i_nbase;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step && i_last && i_mate) begin
            r_pr_ctl.n_seen <= r_n_seen || i_nbase;
            r_pr_ctl.type_first <= r_first_type;
            r_pr_ctl.type_second <= w_type;
            r_pos_first <= r_first_pos;
            r_len_first <= r_first_len;
            r_pos_second <= w_pos;
            r_len_second <= i_count;
        end
    end

    assign o_pr_valid = r_pr_valid;
    assign o_pr_ctl = r_pr_ctl;
    assign o_pos_first = r_pos_first;
    assign o_len_first = r_len_first;
    assign o_pos_second = r_pos_second;
    assign o_len_second = r_len_second;

endmodule

@@ rtl/prlc_class.sv @@
// ----------------------------------------------------------------------------
// prlc_class
// Applies the N check, length bounds and rescue mode; holds the result item.
// ----------------------------------------------------------------------------
module prlc_class #(
    parameter int CW = 9
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_pr_valid,
    input  prlc_pkg::t_pair_ctl                 i_pr_ctl,
    input  logic [CW-1:0]                       i_pos_first,
    input  logic [CW-1:0]                       i_len_first,
    input  logic [CW-1:0]                       i_pos_second,
    input  logic [CW-1:0]                       i_len_second,
    input  logic [prlc_pkg::RESCUE_W-1:0]       i_rescue,
    input  logic [prlc_pkg::BOUND_W-1:0]        i_min_len,
    input  logic [prlc_pkg::BOUND_W-1:0]        i_max_len,
    input  logic                                i_out_ready,
    output logic                                o_take,
    output logic                                o_out_valid,
    output prlc_pkg::t_out_item                 o_out_data
);

    localparam int LW = (CW > prlc_pkg::BOUND_W) ? CW : prlc_pkg::BOUND_W;

    logic                r_out_valid;
    prlc_pkg::t_out_item r_out_data;

    logic                n_take;
    prlc_pkg::t_class    w_class;
    logic [CW-1:0]       w_cut1;
    logic [CW-1:0]       w_cut2;
    logic [CW-1:0]       w_v1;
    logic [CW-1:0]       w_v2;
    logic                w_oob;
    logic                w_t1;
    logic                w_t2;
    logic                w_resc_first;
    logic                w_resc_second;
    logic                w_resc_both;

    always_comb begin
        n_take = i_pr_valid && (!r_out_valid || i_out_ready);
        w_t1 = (i_pr_ctl.type_first != prlc_pkg::LT_NONE);
        w_t2 = (i_pr_ctl.type_second != prlc_pkg::LT_NONE);
        w_v1 = w_t1 ? i_pos_first : i_len_first;
        w_v2 = w_t2 ? i_pos_second : i_len_second;
        w_oob = (LW'(w_v1) < LW'(i_min_len)) || (LW'(w_v1) > LW'(i_max_len))
             || (LW'(w_v2) < LW'(i_min_len)) || (LW'(w_v2) > LW'(i_max_len));
        w_resc_first = (i_rescue == prlc_pkg::RESCUE_FIRST)
                    || (i_rescue == prlc_pkg::RESCUE_ANY);
        w_resc_second = (i_rescue == prlc_pkg::RESCUE_SECOND)
                     || (i_rescue == prlc_pkg::RESCUE_ANY);
        w_resc_both = (i_rescue == prlc_pkg::RESCUE_ANY)
                   || (i_rescue == prlc_pkg::RESCUE_BOTH);
        w_class = prlc_pkg::CLS_AMBIGUOUS;
        w_cut1 = i_len_first;
        w_cut2 = i_len_second;
        priority if (i_pr_ctl.n_seen) begin
            w_class = prlc_pkg::CLS_HAS_N;
        end else if (w_oob) begin
            w_class = prlc_pkg::CLS_AMBIGUOUS;
        end else if (w_t1 && (i_pr_ctl.type_first == i_pr_ctl.type_second)) begin
            w_class = prlc_pkg::CLS_USABLE;
            w_cut1 = i_pos_first;
            w_cut2 = i_pos_second;
        end else if (w_t1 && w_t2) begin
            w_class = prlc_pkg::CLS_CHIMERIC;
        end else if (!w_t1 && w_t2 && w_resc_first) begin
            w_class = prlc_pkg::CLS_USABLE;
            w_cut2 = i_pos_second;
        end else if (w_t1 && !w_t2 && w_resc_second) begin
            w_class = prlc_pkg::CLS_USABLE;
            w_cut1 = i_pos_first;
        end else if (!w_t1 && !w_t2 && w_resc_both) begin
            w_class = prlc_pkg::CLS_USABLE;
        end else begin
            w_class = prlc_pkg::CLS_AMBIGUOUS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (n_take) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_take) begin
            r_out_data.pair_class <= w_class;
            r_out_data.cut_first <= w_cut1[prlc_pkg::CUT_W-1:0];
            r_out_data.cut_second <= w_cut2[prlc_pkg::CUT_W-1:0];
        end
    end

    assign o_take = n_take;
    assign o_out_valid = r_out_valid;
    assign o_out_data = r_out_data;

endmodule
